@@ sv/ipsl_pkg.sv @@
`default_nettype none

package ipsl_pkg;

	localparam int FIELD_W     = 16;
	localparam int SETPOINT_W  = 12;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int PWM_W       = 15;
	localparam int DIST_W      = 32;
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 80;

	// Shared multiplier: signed A operand, unsigned B operand.
	localparam int MUL_A_W     = 23;
	localparam int MUL_B_W     = 20;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W + 1;

	// Constant division: dividend, pre-shifted magnitude and quotient widths.
	localparam int DVD_W       = 34;
	localparam int DIVX_W      = 22;
	localparam int QUO_W       = 22;
	localparam int RECIP_SHIFT = 22;
	localparam int DIVC_W      = 7;

	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DELTA_GAIN = 3'd7;

	// Divisor kinds: 25600 = 2^10*25, 20480 = 2^12*5, 256000 = 2^11*125.
	localparam logic [1:0] DK_25600  = 2'd0;
	localparam logic [1:0] DK_20480  = 2'd1;
	localparam logic [1:0] DK_256000 = 2'd2;

	localparam logic [DIVC_W-1:0] DIVC_25  = 7'd25;
	localparam logic [DIVC_W-1:0] DIVC_5   = 7'd5;
	localparam logic [DIVC_W-1:0] DIVC_125 = 7'd125;

	// floor(2^22 / c) for each odd divisor.
	localparam logic [MUL_B_W-1:0] RECIP_25  = 20'd167772;
	localparam logic [MUL_B_W-1:0] RECIP_5   = 20'd838860;
	localparam logic [MUL_B_W-1:0] RECIP_125 = 20'd33554;

	localparam logic signed [FIELD_W-1:0] FLOOR_SPEED = 16'sd185;
	localparam logic signed [PWM_W+1:0]   PWM_MAX     = 17'sd10000;
	localparam logic signed [PWM_W+1:0]   PWM_MIN     = -17'sd2000;

	typedef struct packed {
		logic [SETPOINT_W-1:0] setpoint;
		logic [CFG_W-1:0]      area_low;
		logic [CFG_W-1:0]      area_high;
		logic [CFG_W-1:0]      decel_gain;
		logic [CFG_W-1:0]      accel_gain;
		logic [CFG_W-1:0]      steer_gain;
		logic [CFG_W-1:0]      error_gain;
		logic [CFG_W-1:0]      delta_gain;
	} cfg_t;

endpackage

`default_nettype wire

@@ sv/ipsl_regs.sv @@
`default_nettype none

module ipsl_regs import ipsl_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETPOINT:   cfg_q.setpoint   <= cfg_data[SETPOINT_W-1:0];
				REG_AREA_LOW:   cfg_q.area_low   <= cfg_data;
				REG_AREA_HIGH:  cfg_q.area_high  <= cfg_data;
				REG_DECEL_GAIN: cfg_q.decel_gain <= cfg_data;
				REG_ACCEL_GAIN: cfg_q.accel_gain <= cfg_data;
				REG_STEER_GAIN: cfg_q.steer_gain <= cfg_data;
				REG_ERROR_GAIN: cfg_q.error_gain <= cfg_data;
				REG_DELTA_GAIN: cfg_q.delta_gain <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ sv/ipsl_mul.sv @@
`default_nettype none

module ipsl_mul import ipsl_pkg::*; (
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic        [MUL_B_W-1:0] b,
	output logic signed      [MUL_P_W-1:0] prod_q
);

	logic signed [MUL_P_W-1:0] a_ext;
	logic signed [MUL_P_W-1:0] b_ext;

	assign a_ext = {{(MUL_P_W-MUL_A_W){a[MUL_A_W-1]}}, a};
	assign b_ext = {{(MUL_P_W-MUL_B_W){1'b0}}, b};

	always_ff @(posedge clk) begin
		prod_q <= a_ext * b_ext;
	end

endmodule

`default_nettype wire

@@ sv/incremental_pi_speed_loop.sv @@
`default_nettype none

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  wheel speeds, blob area/centre, steer
// m_axis    out        m_axis_tvalid / m_axis_tready  drive_pwm, speeds, travelled distance
// cfg       in         cfg_we (no wait)               register index and data
//
// One control tick runs from acceptance to a loaded result; s_axis_tready stays low until
// the tick has finished, so no new transaction is accepted before then. The pace is
// set by the single registered multiplier: four products, the two PI terms summed, feed
// three constant divisions, each a reciprocal multiply with a one-step correction, all
// sequenced through the same unit.
// Reset clears the configuration, the loop state and the sequencer; no clearing pass.
// A result waits in the output register; a finished tick stalls there until it is free.

module incremental_pi_speed_loop import ipsl_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [15:0] left_wheel_speed, [31:16] right_wheel_speed, [47:32] blob_area,
	// [63:48] blob_centre, [79:64] steer_command
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [14:0] drive_pwm, [30:15] measured_speed, [46:31] target_speed,
	// [78:47] travelled, [79] zero
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_START   = 5'd1;
	localparam logic [4:0] ST_IMG_MUL = 5'd2;
	localparam logic [4:0] ST_STR_MUL = 5'd3;
	localparam logic [4:0] ST_DV_PREP = 5'd4;
	localparam logic [4:0] ST_DV_MUL  = 5'd5;
	localparam logic [4:0] ST_DV_FIX  = 5'd6;
	localparam logic [4:0] ST_TARGET  = 5'd7;
	localparam logic [4:0] ST_ERR     = 5'd8;
	localparam logic [4:0] ST_PI1     = 5'd9;
	localparam logic [4:0] ST_PI2     = 5'd10;
	localparam logic [4:0] ST_PISUM   = 5'd11;
	localparam logic [4:0] ST_PWM     = 5'd12;

	localparam logic [1:0] PH_IMG   = 2'd0;
	localparam logic [1:0] PH_STEER = 2'd1;
	localparam logic [1:0] PH_PI    = 2'd2;

	cfg_t cfg;

	logic [4:0] state_q;
	logic [1:0] phase_q;
	logic [1:0] kind_q;

	logic signed [FIELD_W-1:0] meas_q;
	logic signed [FIELD_W-1:0] centre_q;
	logic        [FIELD_W:0]   area_q;
	logic        [FIELD_W:0]   steer_q;
	logic signed [FIELD_W+1:0] diff_q;
	logic        [CFG_W-1:0]   gain_q;
	logic signed [QUO_W-1:0]   img_q;
	logic signed [QUO_W-1:0]   quo_q;
	logic signed [FIELD_W-1:0] target_q;
	logic signed [FIELD_W-1:0] e_q;
	logic signed [FIELD_W-1:0] de_q;
	logic signed [DVD_W-1:0]   acc_q;
	logic        [DIVX_W-1:0]  x_q;
	logic                      neg_q;

	logic signed [FIELD_W-1:0] prev_q;
	logic signed [PWM_W-1:0]   pwm_q;
	logic        [DIST_W-1:0]  dist_q;

	logic                      m_valid_q;
	logic [OUT_DATA_W-1:0]     m_data_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic        [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_q;

	ipsl_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ipsl_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Input unpacking and the work done on the accepting edge.
	logic signed [FIELD_W-1:0] in_left, in_right, in_area, in_centre, in_steer;
	logic signed [FIELD_W:0]   wheel_sum;
	logic signed [FIELD_W:0]   meas_full;
	logic signed [FIELD_W:0]   area_ext, steer_ext;
	logic                      in_fire;

	assign in_left   = s_axis_tdata[15:0];
	assign in_right  = s_axis_tdata[31:16];
	assign in_area   = s_axis_tdata[47:32];
	assign in_centre = s_axis_tdata[63:48];
	assign in_steer  = s_axis_tdata[79:64];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign wheel_sum = {in_left[15], in_left} + {in_right[15], in_right};
	// Arithmetic shift floors; add one back for odd negative sums to truncate.
	assign meas_full = (wheel_sum >>> 1) + $signed({16'd0, wheel_sum[16] & wheel_sum[0]});
	assign area_ext  = {in_area[15], in_area};
	assign steer_ext = {in_steer[15], in_steer};

	logic signed [FIELD_W-1:0] meas_half;
	assign meas_half = (meas_q >>> 1) + $signed({15'd0, meas_q[15] & meas_q[0]});

	// Image branch selection.
	logic area_ge_low, area_le_high;
	assign area_ge_low  = area_q >= {1'b0, cfg.area_low};
	assign area_le_high = area_q <= {1'b0, cfg.area_high};

	// Constant division: magnitude, pre-shift and reciprocal selection.
	logic signed [DVD_W-1:0]  dvd;
	logic        [DVD_W-1:0]  dvd_mag;
	logic        [DIVX_W-1:0] x_next;
	logic        [MUL_B_W-1:0] recip_sel;
	logic        [DIVC_W-1:0] divc_sel;

	assign dvd     = (phase_q == PH_PI) ? acc_q : prod_q[DVD_W-1:0];
	assign dvd_mag = dvd[DVD_W-1] ? DVD_W'(-dvd) : DVD_W'(dvd);

	always_comb begin
		case (kind_q)
			DK_25600: begin
				x_next    = dvd_mag[31:10];
				recip_sel = RECIP_25;
				divc_sel  = DIVC_25;
			end
			DK_20480: begin
				x_next    = {2'b00, dvd_mag[31:12]};
				recip_sel = RECIP_5;
				divc_sel  = DIVC_5;
			end
			DK_256000: begin
				x_next    = {1'b0, dvd_mag[31:11]};
				recip_sel = RECIP_125;
				divc_sel  = DIVC_125;
			end
			default: begin
				x_next    = dvd_mag[31:10];
				recip_sel = RECIP_25;
				divc_sel  = DIVC_25;
			end
		endcase
	end

	// The reciprocal estimate is exact or one short; one compare fixes it.
	logic [MUL_B_W-1:0]  q_est;
	logic [DIVX_W:0]     q_times_c;
	logic [DIVX_W:0]     q_rem;
	logic                q_bump;
	logic [DIVX_W:0]     q_rem_fixed;
	logic [MUL_B_W:0]    q_fixed;
	logic signed [QUO_W-1:0] q_signed;
	logic signed [QUO_W-1:0] quo_next;

	assign q_est       = prod_q[RECIP_SHIFT+MUL_B_W-1:RECIP_SHIFT];
	assign q_times_c   = (DIVX_W+1)'({3'b000, q_est} * {16'd0, divc_sel});
	assign q_rem       = {1'b0, x_q} - q_times_c;
	assign q_bump      = q_rem >= {16'd0, divc_sel};
	assign q_rem_fixed = q_bump ? q_rem - {16'd0, divc_sel} : q_rem;
	assign q_fixed     = {1'b0, q_est} + {20'd0, q_bump};
	assign q_signed    = {1'b0, q_fixed};
	assign quo_next    = neg_q ? -q_signed : q_signed;

	// Target, error and accumulator update.
	logic signed [FIELD_W-1:0] target_raw;
	logic signed [PWM_W+1:0]   pwm_sum;
	logic signed [PWM_W-1:0]   pwm_next;
	logic                      out_free;

	assign target_raw = {4'd0, cfg.setpoint} - img_q[FIELD_W-1:0] - quo_q[FIELD_W-1:0];
	assign pwm_sum    = {{2{pwm_q[PWM_W-1]}}, pwm_q} + {quo_q[FIELD_W-1], quo_q[FIELD_W-1:0]};

	always_comb begin
		if (pwm_sum > PWM_MAX) begin
			pwm_next = PWM_MAX[PWM_W-1:0];
		end else if (pwm_sum < PWM_MIN) begin
			pwm_next = PWM_MIN[PWM_W-1:0];
		end else begin
			pwm_next = pwm_sum[PWM_W-1:0];
		end
	end

	assign out_free = !m_valid_q || m_axis_tready;

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			ST_IMG_MUL: begin
				mul_a = {{5{diff_q[FIELD_W+1]}}, diff_q};
				mul_b = {4'd0, gain_q};
			end
			ST_STR_MUL: begin
				mul_a = {6'd0, steer_q};
				mul_b = {4'd0, cfg.steer_gain};
			end
			ST_DV_MUL: begin
				mul_a = {1'b0, x_q};
				mul_b = recip_sel;
			end
			ST_PI1: begin
				mul_a = {{7{e_q[FIELD_W-1]}}, e_q};
				mul_b = {4'd0, cfg.error_gain};
			end
			ST_PI2: begin
				mul_a = {{7{de_q[FIELD_W-1]}}, de_q};
				mul_b = {4'd0, cfg.delta_gain};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Sequencer and loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_IMG;
			kind_q    <= DK_25600;
			prev_q    <= '0;
			pwm_q     <= '0;
			dist_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_PWM && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					dist_q <= dist_q + {{16{meas_half[15]}}, meas_half};
					if (area_ge_low && area_le_high) begin
						kind_q <= DK_25600;
					end else if (!area_le_high) begin
						kind_q <= DK_20480;
					end else begin
						kind_q <= DK_25600;
					end
					state_q <= ST_IMG_MUL;
				end
				ST_IMG_MUL: begin
					phase_q <= PH_IMG;
					state_q <= ST_DV_PREP;
				end
				ST_STR_MUL: begin
					phase_q <= PH_STEER;
					kind_q  <= DK_256000;
					state_q <= ST_DV_PREP;
				end
				ST_DV_PREP: begin
					state_q <= ST_DV_MUL;
				end
				ST_DV_MUL: begin
					state_q <= ST_DV_FIX;
				end
				ST_DV_FIX: begin
					case (phase_q)
						PH_IMG:   state_q <= ST_STR_MUL;
						PH_STEER: state_q <= ST_TARGET;
						PH_PI:    state_q <= ST_PWM;
						default:  state_q <= ST_IDLE;
					endcase
				end
				ST_TARGET: begin
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					state_q <= ST_PI1;
				end
				ST_PI1: begin
					state_q <= ST_PI2;
				end
				ST_PI2: begin
					state_q <= ST_PISUM;
				end
				ST_PISUM: begin
					phase_q <= PH_PI;
					kind_q  <= DK_25600;
					state_q <= ST_DV_PREP;
				end
				ST_PWM: begin
					if (out_free) begin
						pwm_q   <= pwm_next;
						prev_q  <= e_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; these carry payload only and need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					meas_q   <= meas_full[FIELD_W-1:0];
					centre_q <= in_centre;
					area_q   <= in_area[15] ? (FIELD_W+1)'(-area_ext) : (FIELD_W+1)'(area_ext);
					steer_q  <= in_steer[15] ? (FIELD_W+1)'(-steer_ext)
					                         : (FIELD_W+1)'(steer_ext);
				end
			end
			ST_START: begin
				diff_q <= $signed({1'b0, area_q}) - $signed({2'b00, cfg.area_low});
				// Below the low threshold only a centre beyond 10 gives a boost.
				if (area_ge_low || !area_le_high) begin
					gain_q <= cfg.decel_gain;
				end else if (centre_q > 16'sd10) begin
					gain_q <= cfg.accel_gain;
				end else begin
					gain_q <= '0;
				end
			end
			ST_DV_PREP: begin
				neg_q <= dvd[DVD_W-1];
				x_q   <= x_next;
			end
			ST_DV_FIX: begin
				quo_q <= quo_next;
				if (phase_q == PH_IMG) begin
					img_q <= quo_next;
				end
			end
			ST_TARGET: begin
				target_q <= (meas_q < FLOOR_SPEED) ? FLOOR_SPEED : target_raw;
			end
			ST_ERR: begin
				e_q  <= target_q - meas_q;
				de_q <= target_q - meas_q - prev_q;
			end
			ST_PI2: begin
				acc_q <= prod_q[DVD_W-1:0];
			end
			ST_PISUM: begin
				acc_q <= acc_q + prod_q[DVD_W-1:0];
			end
			ST_PWM: begin
				if (out_free) begin
					m_data_q <= {1'b0, dist_q, target_q, meas_q, pwm_next};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// The accumulator never leaves the clamp range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pwm_q <= PWM_MAX) && (pwm_q >= PWM_MIN))
		else $error("pwm accumulator outside clamp range");

	// A finished tick must not overwrite a result that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PWM && m_valid_q && !m_axis_tready) |=> $stable(m_data_q))
		else $error("waiting result overwritten");

	// After correction the division remainder is below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DV_FIX) |-> (q_rem_fixed < {16'd0, divc_sel}))
		else $error("constant division correction out of range");

	// The output holds the current accumulator once the result is loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PWM && out_free) |=> (m_data_q[PWM_W-1:0] == pwm_q) && m_valid_q)
		else $error("loaded result does not match accumulator");

endmodule

`default_nettype wire
